@@ design/tmcr_pkg.sv @@
// Package: shared types and constants of the column raycaster.
`default_nettype none
package tmcr_pkg;
  typedef struct packed {
    logic [6:0]  column;
    logic [15:0] viewer_x;
    logic [15:0] viewer_y;
    logic [15:0] heading;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  row;
    logic [2:0]  glyph;
    logic [16:0] wall_distance;
    logic        last_row;
  } out_item_t;

  localparam logic [2:0] REG_MAP0  = 3'd0;
  localparam logic [2:0] REG_MAP1  = 3'd1;
  localparam logic [2:0] REG_MAP2  = 3'd2;
  localparam logic [2:0] REG_MAP3  = 3'd3;
  localparam logic [2:0] REG_FOV   = 3'd4;
  localparam logic [2:0] REG_STEP  = 3'd5;
  localparam logic [2:0] REG_DEPTH = 3'd6;

  localparam logic [2:0] GLYPH_BLANK  = 3'd0;
  localparam logic [2:0] GLYPH_FULL   = 3'd1;
  localparam logic [2:0] GLYPH_DARK   = 3'd2;
  localparam logic [2:0] GLYPH_MEDIUM = 3'd3;
  localparam logic [2:0] GLYPH_LIGHT  = 3'd4;
endpackage
`default_nettype wire

@@ design/tile_map_column_raycaster_core.sv @@
// Top level: column raycaster with sequencer, shared multiplier and divider.
// Sequence: form the angle, fetch the direction, march the ray on the shared multiplier
//   for at most ceil(depth_limit*4096/march_step) steps, 160 at reset, divide for the
//   ceiling row, shade, then emit every row; depth_limit 0 skips the march and divide.
//   A new column is taken only once the last row of the previous one is on the output.
// Reset (rst, synchronous): registers take their listed reset values, the
//   sequencer returns to idle and no result is held.
`default_nettype none
module tile_map_column_raycaster_core #(
  parameter int SCREEN_WIDTH    = 120,
  parameter int SCREEN_HEIGHT   = 40,
  parameter int MAP_SIDE        = 16,
  parameter int SINE_TABLE_BITS = 10
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  output logic                    in_stall,
  input  wire tmcr_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire                     out_stall,
  output tmcr_pkg::out_item_t     out_data,
  input  wire                     psel,
  input  wire                     penable,
  input  wire                     pwrite,
  input  wire  [5:0]              paddr,
  input  wire  [63:0]             pwdata,
  output logic [63:0]             prdata,
  output logic                    pready
);
  localparam int NENT = 1 << SINE_TABLE_BITS;
  localparam int QSZ  = NENT / 4;
  localparam int QB   = SINE_TABLE_BITS - 2;
  // Reciprocal of the screen width, exact for every column*fov product.
  localparam logic [32:0] RECIP =
    33'(((64'd1 << 32) + 64'(SCREEN_WIDTH) - 64'd1) / 64'(SCREEN_WIDTH));

  // One-hot sequencer states.
  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_ANG   = 10'b0000000010,
    S_DIV   = 10'b0000000100,
    S_SIN   = 10'b0000001000,
    S_STEP  = 10'b0000010000,
    S_MX    = 10'b0000100000,
    S_MY    = 10'b0001000000,
    S_CEIL  = 10'b0010000000,
    S_SHADE = 10'b0100000000,
    S_EMIT  = 10'b1000000000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [63:0] map_rows [4];
  logic [14:0] fov;
  logic [11:0] mstep;
  logic [4:0]  dlim;

  wire cfg_wr = psel && penable && pwrite;
  wire [2:0] cfg_idx = paddr[5:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) map_rows[i] <= '0;
      fov   <= 15'd8192;
      mstep <= 12'd410;
      dlim  <= 5'd16;
    end else if (cfg_wr) begin
      case (cfg_idx)
        tmcr_pkg::REG_MAP0:  map_rows[0] <= pwdata;
        tmcr_pkg::REG_MAP1:  map_rows[1] <= pwdata;
        tmcr_pkg::REG_MAP2:  map_rows[2] <= pwdata;
        tmcr_pkg::REG_MAP3:  map_rows[3] <= pwdata;
        tmcr_pkg::REG_FOV:   fov   <= pwdata[14:0];
        tmcr_pkg::REG_STEP:  mstep <= pwdata[11:0];
        tmcr_pkg::REG_DEPTH: dlim  <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  assign pready = 1'b1;
  always_comb begin
    case (cfg_idx)
      tmcr_pkg::REG_MAP0:  prdata = map_rows[0];
      tmcr_pkg::REG_MAP1:  prdata = map_rows[1];
      tmcr_pkg::REG_MAP2:  prdata = map_rows[2];
      tmcr_pkg::REG_MAP3:  prdata = map_rows[3];
      tmcr_pkg::REG_FOV:   prdata = {49'd0, fov};
      tmcr_pkg::REG_STEP:  prdata = {52'd0, mstep};
      tmcr_pkg::REG_DEPTH: prdata = {59'd0, dlim};
      default:             prdata = '0;
    endcase
  end

  // Quarter-wave sine polynomial; only ever evaluated on constants to fill the table.
  function automatic logic [12:0] quarter_sine(input logic [QB:0] ph);
    logic [63:0] t, t2, a, b, s, q;
    t  = 64'(ph) << (17 - SINE_TABLE_BITS);
    t2 = (t * t) >> 15;
    a  = 64'd21167 - ((t2 * 64'd2611) >> 15);
    b  = 64'd51472 - ((t2 * a) >> 15);
    s  = (t * b) >> 15;
    q  = (s + 64'd4) >> 3;
    return (q > 64'd4096) ? 13'd4096 : q[12:0];
  endfunction

  // Constant quarter-wave table, end points included.
  logic [12:0] sine_tab [QSZ+1];
  for (genvar g = 0; g <= QSZ; g++) begin : g_sine_tab
    assign sine_tab[g] = quarter_sine((QB+1)'(g));
  end

  // Item registers.
  tmcr_pkg::in_item_t item;
  logic [15:0]        angle;
  logic signed [13:0] ex, ey;
  logic [12:0]        mag_x, mag_y;
  logic               neg_x, neg_y;
  logic [16:0]        ray_dist;
  logic [17:0]        lim;
  logic               ok_x;
  logic [3:0]         cx;

  // Table addresses: mirror the phase in odd quadrants, negate in the lower half-turn.
  wire [SINE_TABLE_BITS-1:0] idx_x = angle[15 -: SINE_TABLE_BITS];
  wire [SINE_TABLE_BITS-1:0] idx_y = idx_x + SINE_TABLE_BITS'(QSZ);
  wire [QB:0] tab_x = idx_x[QB] ? (QB+1)'(QSZ) - {1'b0, idx_x[QB-1:0]}
                                : {1'b0, idx_x[QB-1:0]};
  wire [QB:0] tab_y = idx_y[QB] ? (QB+1)'(QSZ) - {1'b0, idx_y[QB-1:0]}
                                : {1'b0, idx_y[QB-1:0]};

  always_comb begin
    ex = neg_x ? -$signed({1'b0, mag_x}) : $signed({1'b0, mag_x});
    ey = neg_y ? -$signed({1'b0, mag_y}) : $signed({1'b0, mag_y});
  end

  // Shared restoring divider: 32-bit dividend / 17-bit divisor, one bit a cycle.
  logic [31:0] dv_q;
  logic [17:0] dv_r;
  logic [16:0] dv_d;
  logic [5:0]  dv_cnt;
  wire  [17:0] dv_trial = {dv_r[16:0], dv_q[31]};
  wire         dv_ge    = dv_trial >= {1'b0, dv_d};

  // column*fov / SCREEN_WIDTH by reciprocal multiplication; low 16 bits suffice.
  wire [54:0] ang_prod = 55'(dv_q[21:0]) * 55'(RECIP);
  wire [15:0] ang_quot = ang_prod[47:32];

  logic signed [19:0] ceiling;
  logic signed [19:0] floor_row;
  logic [2:0]         shade;
  logic [5:0]         row;
  logic               div_ceil;

  // Shared multiplier: signed direction by unsigned distance.
  logic signed [13:0] mul_a;
  wire  signed [31:0] mul_p = mul_a * $signed({1'b0, ray_dist});
  always_comb mul_a = state == S_MY ? ey : ex;

  wire [11:0] step_eff = (mstep == 12'd0) ? 12'd1 : mstep;
  wire [16:0] dist_nx  = ray_dist + 17'(step_eff);
  logic signed [41:0] sum_x, sum_y;
  always_comb begin
    sum_x = $signed({14'd0, item.viewer_x, 12'd0}) + 42'(mul_p);
    sum_y = $signed({14'd0, item.viewer_y, 12'd0}) + 42'(mul_p);
  end
  wire in_x = !sum_x[41] && (sum_x[41:24] < 18'(MAP_SIDE));
  wire in_y = !sum_y[41] && (sum_y[41:24] < 18'(MAP_SIDE));
  wire [3:0] cy = sum_y[27:24];
  wire wall = map_rows[cy[3:2]][{cy[1:0], cx}];

  wire signed [31:0] cq = $signed(32'(SCREEN_HEIGHT * 2048)) - $signed(dv_q);

  assign in_stall = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) begin
          item  <= in_data;
          state <= S_ANG;
        end
        S_ANG: begin
          // Form column*fov; the reciprocal multiply divides it next cycle.
          dv_q     <= {10'd0, 22'(item.column) * 22'(fov)};
          div_ceil <= 1'b0;
          state    <= S_SIN;
        end
        S_DIV: begin
          dv_q   <= {dv_q[30:0], dv_ge};
          dv_r   <= dv_ge ? dv_trial - {1'b0, dv_d} : dv_trial;
          dv_cnt <= dv_cnt + 6'd1;
          if (dv_cnt == 6'd31) state <= S_CEIL;
        end
        S_SIN: begin
          angle <= item.heading - 16'(fov >> 1) + ang_quot;
          state <= S_STEP;
        end
        S_STEP: begin
          // angle settled; fetch direction and reset the march.
          mag_x <= sine_tab[tab_x];
          mag_y <= sine_tab[tab_y];
          neg_x <= idx_x[QB+1];
          neg_y <= idx_y[QB+1];
          lim   <= {1'b0, dlim, 12'd0};
          ray_dist <= (dlim == 5'd0) ? 17'd0 : 17'(step_eff);
          state <= (dlim == 5'd0) ? S_CEIL : S_MX;
        end
        S_MX: begin
          ok_x  <= in_x;
          cx    <= sum_x[27:24];
          state <= S_MY;
        end
        S_MY: begin
          if (!ok_x || !in_y) begin
            ray_dist <= lim[16:0];
            state    <= S_CEIL;
          end else if (wall || {1'b0, ray_dist} >= lim) begin
            state <= S_CEIL;
          end else begin
            ray_dist <= dist_nx;
            state    <= S_MX;
          end
        end
        S_CEIL: begin
          if (ray_dist == 17'd0) begin
            ceiling <= '0;
            state   <= S_SHADE;
          end else if (!div_ceil) begin
            dv_q     <= 32'(SCREEN_HEIGHT) << 24;
            dv_r     <= '0;
            dv_d     <= ray_dist;
            dv_cnt   <= '0;
            div_ceil <= 1'b1;
            state    <= S_DIV;
          end else begin
            ceiling <= cq[31] ? -20'((-cq) >>> 12) : 20'(cq >>> 12);
            state   <= S_SHADE;
          end
        end
        S_SHADE: begin
          floor_row <= 20'(SCREEN_HEIGHT) - ceiling;
          if ({ray_dist, 2'b0} <= 19'(lim) && lim != '0) shade <= tmcr_pkg::GLYPH_FULL;
          else if (20'(ray_dist) * 20'd3 < 20'(lim))     shade <= tmcr_pkg::GLYPH_DARK;
          else if ({ray_dist, 1'b0} < 18'(lim))          shade <= tmcr_pkg::GLYPH_MEDIUM;
          else if ({1'b0, ray_dist} < lim)               shade <= tmcr_pkg::GLYPH_LIGHT;
          else                                           shade <= tmcr_pkg::GLYPH_BLANK;
          row       <= '0;
          state     <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid              <= 1'b1;
            out_data.row           <= row;
            out_data.glyph         <= ($signed({14'b0, row}) > ceiling &&
                                       $signed({14'b0, row}) <= floor_row) ? shade
                                       : tmcr_pkg::GLYPH_BLANK;
            out_data.wall_distance <= ray_dist;
            out_data.last_row      <= row == 6'(SCREEN_HEIGHT - 1);
            row                    <= row + 6'd1;
            if (row == 6'(SCREEN_HEIGHT - 1)) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (state != S_EMIT && out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

`ifndef SYNTH
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> in_stall) else $error("input taken while busy");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result dropped under stall");
  a_lim: assert property (@(posedge clk) disable iff (rst)
    state == S_CEIL |-> {1'b0, ray_dist} <= lim + 18'd4096) else $error("march overrun");
`endif
endmodule
`default_nettype wire

@@ test/tmcr_checker.sv @@
// Checker for the column raycaster: watches the channels, predicts rows and compares.
`timescale 1ns / 1ps
module tmcr_checker (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  input  wire                     in_stall,
  input  wire tmcr_pkg::in_item_t in_data,
  input  wire                     out_valid,
  input  wire                     out_stall,
  input  wire tmcr_pkg::out_item_t out_data,
  input  wire                     psel,
  input  wire                     penable,
  input  wire                     pwrite,
  input  wire  [5:0]              paddr,
  input  wire  [63:0]             pwdata,
  input  wire                     pready,
  output int                      failures,
  output int                      rows_pending
);
  localparam int WIDTH  = 120;
  localparam int HEIGHT = 40;
  localparam int SIDE   = 16;
  localparam int TBITS  = 10;

  logic [63:0] map_bits [4];
  logic [14:0] fov;
  logic [11:0] step_size;
  logic [4:0]  depth;
  tmcr_pkg::out_item_t expected_rows [$];

  function automatic int unsigned quarter_wave(int unsigned ph);
    longint unsigned t, t2, a, b, s, q;
    t  = longint'(ph) << (17 - TBITS);
    t2 = (t * t) >> 15;
    a  = 21167 - ((t2 * 2611) >> 15);
    b  = 51472 - ((t2 * a) >> 15);
    s  = (t * b) >> 15;
    q  = (s + 4) >> 3;
    return (q > 4096) ? 4096 : int'(q);
  endfunction

  function automatic int sine_at(int unsigned idx);
    int unsigned qsize, quad, p, v;
    qsize = 1 << (TBITS - 2);
    quad  = (idx >> (TBITS - 2)) & 3;
    p     = idx & (qsize - 1);
    v     = (quad & 1) ? quarter_wave(qsize - p) : quarter_wave(p);
    return (quad & 2) ? -int'(v) : int'(v);
  endfunction

  // Cell index along one axis, or -1 once the ray is off the map.
  function automatic int cell_along(int unsigned pos, int dir, int unsigned reach);
    longint sum;
    sum = longint'(pos) * 4096 + longint'(dir) * longint'(reach);
    if (sum < 0) return -1;
    if ((sum >>> 24) >= SIDE) return -1;
    return int'(sum >>> 24);
  endfunction

  task automatic cast_column(tmcr_pkg::in_item_t it);
    int unsigned angle, idx, stp, lim, d;
    int          ex, ey, cx, cy, ceiling, floor_row;
    longint      q, cq;
    logic [2:0]  shade;
    bit          hit;
    tmcr_pkg::out_item_t r;
    angle = (int'(it.heading) - (fov >> 1) + (int'(it.column) * fov) / WIDTH) & 16'hFFFF;
    idx   = angle >> (16 - TBITS);
    ex    = sine_at(idx);
    ey    = sine_at((idx + (1 << (TBITS - 2))) & ((1 << TBITS) - 1));
    stp   = (step_size == 0) ? 1 : step_size;
    lim   = int'(depth) << 12;
    d     = 0;
    hit   = 0;
    while (!hit && d < lim) begin
      d += stp;
      cx = cell_along(it.viewer_x, ex, d);
      cy = cell_along(it.viewer_y, ey, d);
      if (cx < 0 || cy < 0) begin
        hit = 1;
        d   = lim;
      end else if (map_bits[cy >> 2][((cy & 3) << 4) + cx]) begin
        hit = 1;
      end
    end
    ceiling = 0;
    if (d != 0) begin
      q  = (longint'(HEIGHT) << 24) / d;
      cq = longint'(HEIGHT) * 2048 - q;
      ceiling = (cq >= 0) ? int'(cq >>> 12) : -int'((-cq) >>> 12);
    end
    floor_row = HEIGHT - ceiling;
    if (longint'(d) * 4 <= lim && lim != 0) shade = tmcr_pkg::GLYPH_FULL;
    else if (longint'(d) * 3 < lim)         shade = tmcr_pkg::GLYPH_DARK;
    else if (longint'(d) * 2 < lim)         shade = tmcr_pkg::GLYPH_MEDIUM;
    else if (d < lim)                       shade = tmcr_pkg::GLYPH_LIGHT;
    else                                    shade = tmcr_pkg::GLYPH_BLANK;
    for (int y = 0; y < HEIGHT; y++) begin
      r.row           = 6'(y);
      r.glyph         = (y > ceiling && y <= floor_row) ? shade : tmcr_pkg::GLYPH_BLANK;
      r.wall_distance = 17'(d);
      r.last_row      = (y == HEIGHT - 1);
      expected_rows   = {expected_rows, r};
    end
  endtask

  assign rows_pending = expected_rows.size();

  always @(posedge clk) begin
    tmcr_pkg::out_item_t e;
    if (rst) begin
      for (int i = 0; i < 4; i++) map_bits[i] <= '0;
      fov       <= 15'd8192;
      step_size <= 12'd410;
      depth     <= 5'd16;
    end else begin
      // mirror register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          tmcr_pkg::REG_MAP0, tmcr_pkg::REG_MAP1,
          tmcr_pkg::REG_MAP2, tmcr_pkg::REG_MAP3: map_bits[paddr[4:3]] <= pwdata;
          tmcr_pkg::REG_FOV:   fov       <= pwdata[14:0];
          tmcr_pkg::REG_STEP:  step_size <= pwdata[11:0];
          tmcr_pkg::REG_DEPTH: depth     <= pwdata[4:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) cast_column(in_data);
      if (out_valid && !out_stall) begin
        if (expected_rows.size() == 0) begin
          $display("%0t: unexpected row transaction %p", $time, out_data);
          failures++;
        end else begin
          e = expected_rows.pop_front();
          if (e !== out_data) begin
            $display("%0t: row mismatch expected %p actual %p", $time, e, out_data);
            failures++;
          end
        end
      end
    end
  end

  initial failures = 0;
endmodule

@@ test/testbench.sv @@
// Testbench top: clock, reset, register set-up, column stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
  logic       clk, rst;
  logic       in_valid, in_stall, out_valid, out_stall;
  tmcr_pkg::in_item_t  in_data;
  tmcr_pkg::out_item_t out_data;
  logic       psel, penable, pwrite, pready;
  logic [5:0] paddr;
  logic [63:0] pwdata, prdata;
  int         failures, rows_pending;
  bit         quiet;      // no idling on either side while set
  int         columns_sent;

  tile_map_column_raycaster_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  tmcr_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .failures(failures), .rows_pending(rows_pending)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #20ms;
    $display("tile_map_column_raycaster_core regression: fail");
    $finish;
  end

  // Receiver: stall at random, except during the quiet stretch.
  always @(negedge clk)
    out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 15);

  // One APB write: setup cycle, then access cycle.
  task automatic reg_write(logic [2:0] idx, logic [63:0] value);
    @(negedge clk);
    psel = 1; penable = 0; pwrite = 1; paddr = {idx, 3'b000}; pwdata = value;
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  // Drain every outstanding row, then allow the sequencer to settle.
  task automatic drain();
    while (rows_pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic configure(logic [63:0] m0, m1, m2, m3,
                           logic [14:0] fv, logic [11:0] st, logic [4:0] dl);
    drain();
    reg_write(tmcr_pkg::REG_MAP0, m0);
    reg_write(tmcr_pkg::REG_MAP1, m1);
    reg_write(tmcr_pkg::REG_MAP2, m2);
    reg_write(tmcr_pkg::REG_MAP3, m3);
    reg_write(tmcr_pkg::REG_FOV, 64'(fv));
    reg_write(tmcr_pkg::REG_STEP, 64'(st));
    reg_write(tmcr_pkg::REG_DEPTH, 64'(dl));
  endtask

  // Offer one column; hold it until it is taken.
  task automatic send_column(logic [6:0] col, logic [15:0] vx, vy, hd);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 15) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    in_data  = '{column: col, viewer_x: vx, viewer_y: vy, heading: hd};
    do @(posedge clk); while (in_stall);
    columns_sent++;
  endtask

  task automatic finish_burst();
    @(negedge clk);
    in_valid = 0;
  endtask

  // Random wall map, with a solid border when asked.
  function automatic logic [63:0] map_word(int density, bit border, int base_row);
    logic [63:0] w;
    int r;
    w = '0;
    for (int b = 0; b < 64; b++) begin
      r = base_row + b / 16;
      w[b] = ($urandom_range(99) < density)
             || (border && (r == 0 || r == 15 || b % 16 == 0 || b % 16 == 15));
    end
    return w;
  endfunction

  task automatic random_columns(int n, bit inside_map);
    for (int i = 0; i < n; i++) begin
      if (inside_map && $urandom_range(9) < 8)
        send_column(7'($urandom_range(119)), 16'($urandom_range(16'h1000, 16'hEFFF)),
                    16'($urandom_range(16'h1000, 16'hEFFF)), 16'($urandom));
      else
        send_column(7'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    logic [63:0] m [4];
    int dl, st;
    rst = 1; quiet = 0; columns_sent = 0;
    in_valid = 0; in_data = '0; out_stall = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Reset values, empty map: every ray leaves the map or reaches the depth limit.
    send_column(7'd0,   16'h8000, 16'h8000, 16'h0000);
    send_column(7'd119, 16'h0000, 16'h0000, 16'hFFFF);
    send_column(7'd127, 16'hFFFF, 16'hFFFF, 16'h8000);
    finish_burst();

    // Bordered room: headings on each quarter, near and far walls.
    for (int i = 0; i < 4; i++) m[i] = map_word(10, 1, 4 * i);
    configure(m[0], m[1], m[2], m[3], 15'd8192, 12'd410, 5'd16);
    send_column(7'd0,   16'h8000, 16'h8000, 16'h0000);
    send_column(7'd60,  16'h8000, 16'h8000, 16'h4000);
    send_column(7'd119, 16'h8000, 16'h8000, 16'h8000);
    send_column(7'd127, 16'h8000, 16'h8000, 16'hC000);
    send_column(7'd30,  16'h1800, 16'h1800, 16'hA000);
    send_column(7'd90,  16'hE800, 16'h1800, 16'h2000);
    send_column(7'd45,  16'h2000, 16'hE000, 16'h6000);
    send_column(7'd10,  16'h0000, 16'hFFFF, 16'hFFFF);
    finish_burst();

    // Hold the sender until every row of that burst is back.
    drain();

    // Widest view, longest step, deepest search.
    for (int i = 0; i < 4; i++) m[i] = map_word(20, 0, 4 * i);
    configure(m[0], m[1], m[2], m[3], 15'd32767, 12'd4095, 5'd31);
    random_columns(20, 1);
    finish_burst();

    // Narrowest view, finest step, shallowest search.
    configure(m[0], m[1], m[2], m[3], 15'd1, 12'd1, 5'd1);
    random_columns(3, 1);
    finish_burst();

    // Zero step acts as one.
    configure(m[0], m[1], m[2], m[3], 15'd100, 12'd0, 5'd1);
    random_columns(2, 1);
    finish_burst();

    // Zero depth: no march, blank column.
    configure(m[0], m[1], m[2], m[3], 15'd20000, 12'd300, 5'd0);
    random_columns(3, 0);
    finish_burst();

    // Solid map: the first step lands in a wall unless it leaves the map.
    configure('1, '1, '1, '1, 15'd8192, 12'd2048, 5'd8);
    random_columns(4, 1);
    finish_burst();

    // Random settings; step kept large enough that the march stays short.
    for (int p = 0; p < 6; p++) begin
      for (int i = 0; i < 4; i++) m[i] = map_word($urandom_range(5, 40), $urandom_range(1), 4 * i);
      dl = $urandom_range(1, 31);
      st = $urandom_range((dl * 4096) / 400 + 1, 4095);
      configure(m[0], m[1], m[2], m[3], 15'($urandom_range(1, 32767)), 12'(st), 5'(dl));
      quiet = (p == 3);
      random_columns(13, 1);
      finish_burst();
      quiet = 0;
    end

    // Let the last rows come back, then settle.
    while (rows_pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Cast %0d columns over reset, extreme and random field of view, step and depth,",
             columns_sent);
    $display("with empty, bordered, random and solid maps under random idling on both sides.");
    if (failures == 0) begin
      $display("tile_map_column_raycaster_core regression: pass");
    end else begin
      $display("tile_map_column_raycaster_core regression: fail");
    end
    $finish;
  end
endmodule

@@ sim.f @@
design/tmcr_pkg.sv
design/tile_map_column_raycaster_core.sv
test/tmcr_checker.sv
test/testbench.sv
